FILE: rtl/core/gf_pm_field_alu_top_defines.svh
// assertion macros shared by the checker
`ifndef GF_PM_FIELD_ALU_TOP_DEFINES_SVH
`define GF_PM_FIELD_ALU_TOP_DEFINES_SVH

// consequent must hold in the same cycle
`define GFPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the next cycle
`define GFPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/gfpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gfpm_pkg;

  localparam int ELEM_W     = 32;
  localparam int BIT_W      = $clog2(ELEM_W);
  localparam int MAX_DEGREE = 31;
  localparam int DIG_W      = $clog2(MAX_DEGREE + 1);
  localparam int EXP_W      = 64;
  localparam int ACT_W      = 3;
  localparam int DEG_W      = 5;
  localparam int CFG_IDX_W  = 2;

  typedef logic [ELEM_W-1:0] elem_t;
  typedef logic [DIG_W-1:0]  didx_t;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD = 3'd0,
    ACT_NEG = 3'd1,
    ACT_MUL = 3'd2,
    ACT_POW = 3'd3,
    ACT_INV = 3'd4
  } act_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PRIME_BASE  = 2'd0,
    REG_DEGREE      = 2'd1,
    REG_MODULUS_LOW = 2'd2,
    REG_FIELD_ORDER = 2'd3
  } reg_idx_t;

  // a + b mod m, both inputs already below m
  function automatic elem_t mod_add(elem_t a, elem_t b, elem_t m);
    logic [ELEM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[ELEM_W-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gfpm_modmul.sv
`timescale 1ns / 1ps
`default_nettype none
module gfpm_modmul (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  gfpm_pkg::elem_t x,
  input  gfpm_pkg::elem_t y,
  input  gfpm_pkg::elem_t p,
  output logic           done,
  output gfpm_pkg::elem_t prod
);
  import gfpm_pkg::*;

  logic             busy;
  logic [BIT_W-1:0] cnt;
  elem_t            xr, yr, pr, acc, dbl, acc_next;

  // msb-first double and add, reduced each bit
  assign dbl      = mod_add(acc, acc, pr);
  assign acc_next = mod_add(dbl, xr[cnt] ? yr : '0, pr);
  assign prod     = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= BIT_W'(ELEM_W - 1);
        acc  <= '0;
        xr   <= x;
        yr   <= y;
        pr   <= p;
      end else if (busy) begin
        acc <= acc_next;
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gfpm_divider.sv
`timescale 1ns / 1ps
`default_nettype none
module gfpm_divider (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  gfpm_pkg::elem_t num,
  input  gfpm_pkg::elem_t den,
  output logic           done,
  output gfpm_pkg::elem_t quot,
  output gfpm_pkg::elem_t rem
);
  import gfpm_pkg::*;

  logic             busy;
  logic [BIT_W-1:0] cnt;
  elem_t            q, r, dr;
  logic [ELEM_W:0]  sh, diff;
  logic             ge;

  // restoring division, one quotient bit a cycle
  assign sh   = {r, q[ELEM_W-1]};
  assign ge   = sh >= {1'b0, dr};
  assign diff = sh - {1'b0, dr};
  assign quot = q;
  assign rem  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= BIT_W'(ELEM_W - 1);
        q    <= num;
        r    <= '0;
        dr   <= den;
      end else if (busy) begin
        r   <= ge ? diff[ELEM_W-1:0] : sh[ELEM_W-1:0];
        q   <= {q[ELEM_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gfpm_packer.sv
`timescale 1ns / 1ps
`default_nettype none
module gfpm_packer (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  gfpm_pkg::elem_t v,
  input  gfpm_pkg::elem_t p,
  input  gfpm_pkg::elem_t dig,
  output logic           done,
  output gfpm_pkg::elem_t res
);
  import gfpm_pkg::*;

  logic             busy;
  logic [BIT_W-1:0] cnt;
  elem_t            t, vr, pr, dgr;

  // v * p + dig, wrapping at the element width
  assign res = t + dgr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= BIT_W'(ELEM_W - 1);
        t    <= '0;
        vr   <= v;
        pr   <= p;
        dgr  <= dig;
      end else if (busy) begin
        t   <= {t[ELEM_W-2:0], 1'b0} + (pr[cnt] ? vr : '0);
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gf_pm_field_alu_top.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   | handshake            | payload
// config    | cfg_wen              | cfg_index, cfg_data
// command   | start, busy          | action, operand_a, operand_b, exponent
// result    | result_valid strobe  | result_value
//
// each digit split is a 32-step division, each pack step a shift-and-add
// multiply, each digit product a 32-step mod-p multiply
// a field multiply's run time is set by the serial mod-p multiplier;
// power and inverse use up to 127 field multiplies
// every item first splits the modulus
// rst is synchronous and idles the block; results cannot be held off
module gf_pm_field_alu_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wen,
  input  logic [gfpm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  gfpm_pkg::elem_t               cfg_data,
  input  logic                         start,
  output logic                         busy,
  input  logic [gfpm_pkg::ACT_W-1:0]    action,
  input  gfpm_pkg::elem_t               operand_a,
  input  gfpm_pkg::elem_t               operand_b,
  input  logic [gfpm_pkg::EXP_W-1:0]    exponent,
  output logic                         result_valid,
  output gfpm_pkg::elem_t               result_value
);
  import gfpm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_SPLIT_GO, S_SPLIT_WAIT, S_DISPATCH, S_POW_CHECK, S_POW_SQUARE,
    S_OP_GO, S_DIGIT, S_ROW_INIT, S_ROW, S_MM_GO, S_MM_WAIT1, S_MM_WAIT2,
    S_JOIN_INIT, S_JOIN_GO, S_JOIN_WAIT
  } state_t;
  typedef enum logic [1:0] {T_MOD, T_X, T_Y} tgt_t;
  typedef enum logic [1:0] {K_ADD, K_NEG, K_MUL} kind_t;
  typedef enum logic [1:0] {R_FINAL, R_ACC, R_BASE} ret_t;

  // configuration
  elem_t             prime_base, modulus_low, field_order;
  logic [DEG_W-1:0]  degree;

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_base  <= elem_t'(2);
      degree      <= DEG_W'(1);
      modulus_low <= '0;
      field_order <= elem_t'(2);
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_PRIME_BASE:  prime_base  <= cfg_data;
        REG_DEGREE:      degree      <= cfg_data[DEG_W-1:0];
        REG_MODULUS_LOW: modulus_low <= cfg_data;
        REG_FIELD_ORDER: field_order <= cfg_data;
        default:         ;
      endcase
    end
  end

  elem_t             p_eff;
  didx_t             dm1;
  logic [EXP_W-1:0]  inv_exp;

  assign p_eff   = (prime_base < elem_t'(2)) ? elem_t'(2) : prime_base;
  assign dm1     = (degree == '0) ? '0 : didx_t'(degree - 1'b1);
  assign inv_exp = (field_order < elem_t'(2)) ? '0 : EXP_W'(field_order - elem_t'(2));

  // sequencer
  state_t            state;
  tgt_t              tgt;
  kind_t             kind;
  ret_t              ret;
  logic [ACT_W-1:0]  act;
  elem_t             av, bv, xv, yv, dv, jv, accv, basev;
  logic [EXP_W-1:0]  ev;
  didx_t             i, j, x_idx;
  logic              first;
  elem_t             lead, nlead, prev, s1;
  elem_t             xd [MAX_DEGREE];
  elem_t             yd [MAX_DEGREE];
  elem_t             md [MAX_DEGREE];
  elem_t             rd [MAX_DEGREE];

  logic  div_start, div_done, mm_start, mm_done, pk_start, pk_done;
  elem_t div_quot, div_rem, mm_prod, pk_res, mm_x, mm_y, x_dig, r_old, t_new, neg_dig;

  assign x_idx   = (state == S_DIGIT) ? j : i;
  assign x_dig   = xd[x_idx];
  assign mm_x    = (state == S_MM_WAIT2) ? nlead : x_dig;
  assign mm_y    = (state == S_MM_WAIT2) ? md[j] : yd[j];
  assign r_old   = first ? '0 : rd[j];
  assign t_new   = mod_add(s1, mm_prod, p_eff);
  assign neg_dig = (x_dig == '0) ? '0 : p_eff - x_dig;

  gfpm_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(dv), .den(p_eff),
    .done(div_done), .quot(div_quot), .rem(div_rem)
  );

  gfpm_modmul u_mm (
    .clk(clk), .rst(rst), .start(mm_start), .x(mm_x), .y(mm_y), .p(p_eff),
    .done(mm_done), .prod(mm_prod)
  );

  gfpm_packer u_pk (
    .clk(clk), .rst(rst), .start(pk_start), .v(jv), .p(p_eff), .dig(rd[j]),
    .done(pk_done), .res(pk_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      busy         <= 1'b0;
      result_valid <= 1'b0;
      div_start    <= 1'b0;
      mm_start     <= 1'b0;
      pk_start     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      div_start    <= 1'b0;
      mm_start     <= 1'b0;
      pk_start     <= 1'b0;
      unique case (state)
        S_IDLE: if (start) begin
          busy  <= 1'b1;
          act   <= action;
          av    <= operand_a;
          bv    <= operand_b;
          ev    <= exponent;
          dv    <= modulus_low;
          tgt   <= T_MOD;
          j     <= '0;
          state <= S_SPLIT_GO;
        end
        S_SPLIT_GO: begin
          div_start <= 1'b1;
          state     <= S_SPLIT_WAIT;
        end
        S_SPLIT_WAIT: if (div_done) begin
          case (tgt)
            T_MOD:   md[j] <= div_rem;
            T_X:     xd[j] <= div_rem;
            default: yd[j] <= div_rem;
          endcase
          if (j == dm1) begin
            j <= '0;
            case (tgt)
              T_MOD: state <= S_DISPATCH;
              T_X: begin
                tgt   <= T_Y;
                dv    <= yv;
                state <= S_SPLIT_GO;
              end
              default: state <= (kind == K_MUL) ? S_ROW_INIT : S_DIGIT;
            endcase
          end else begin
            dv    <= div_quot;
            j     <= j + 1'b1;
            state <= S_SPLIT_GO;
          end
        end
        S_DISPATCH: begin
          xv  <= av;
          yv  <= bv;
          ret <= R_FINAL;
          unique case (act)
            ACT_ADD: begin
              kind  <= K_ADD;
              state <= S_OP_GO;
            end
            ACT_NEG: begin
              kind  <= K_NEG;
              state <= S_OP_GO;
            end
            ACT_MUL: begin
              kind  <= K_MUL;
              state <= S_OP_GO;
            end
            ACT_POW, ACT_INV: begin
              accv  <= elem_t'(1);
              basev <= av;
              if (act == ACT_INV) ev <= inv_exp;
              state <= S_POW_CHECK;
            end
            default: begin
              result_value <= '0;
              result_valid <= 1'b1;
              busy         <= 1'b0;
              state        <= S_IDLE;
            end
          endcase
        end
        S_POW_CHECK: begin
          if (ev == '0) begin
            result_value <= accv;
            result_valid <= 1'b1;
            busy         <= 1'b0;
            state        <= S_IDLE;
          end else if (ev[0]) begin
            xv    <= accv;
            yv    <= basev;
            kind  <= K_MUL;
            ret   <= R_ACC;
            state <= S_OP_GO;
          end else begin
            state <= S_POW_SQUARE;
          end
        end
        S_POW_SQUARE: begin
          // the last square is never used
          if (ev[EXP_W-1:1] == '0) begin
            ev    <= '0;
            state <= S_POW_CHECK;
          end else begin
            xv    <= basev;
            yv    <= basev;
            kind  <= K_MUL;
            ret   <= R_BASE;
            state <= S_OP_GO;
          end
        end
        S_OP_GO: begin
          dv    <= xv;
          tgt   <= T_X;
          j     <= '0;
          state <= S_SPLIT_GO;
        end
        S_DIGIT: begin
          rd[j] <= (kind == K_ADD) ? mod_add(x_dig, yd[j], p_eff) : neg_dig;
          if (j == dm1) state <= S_JOIN_INIT;
          else j <= j + 1'b1;
        end
        S_ROW_INIT: begin
          i     <= dm1;
          first <= 1'b1;
          lead  <= '0;
          state <= S_ROW;
        end
        S_ROW: begin
          // horner row: r = r*x mod m + a_i*b
          nlead <= (lead == '0) ? '0 : p_eff - lead;
          prev  <= '0;
          j     <= '0;
          state <= S_MM_GO;
        end
        S_MM_GO: begin
          mm_start <= 1'b1;
          state    <= S_MM_WAIT1;
        end
        S_MM_WAIT1: if (mm_done) begin
          s1       <= mod_add(prev, mm_prod, p_eff);
          mm_start <= 1'b1;
          state    <= S_MM_WAIT2;
        end
        S_MM_WAIT2: if (mm_done) begin
          rd[j] <= t_new;
          prev  <= r_old;
          if (j == dm1) begin
            lead <= t_new;
            if (i == '0) begin
              state <= S_JOIN_INIT;
            end else begin
              i     <= i - 1'b1;
              first <= 1'b0;
              state <= S_ROW;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_MM_GO;
          end
        end
        S_JOIN_INIT: begin
          jv    <= '0;
          j     <= dm1;
          state <= S_JOIN_GO;
        end
        S_JOIN_GO: begin
          pk_start <= 1'b1;
          state    <= S_JOIN_WAIT;
        end
        S_JOIN_WAIT: if (pk_done) begin
          if (j == '0) begin
            case (ret)
              R_ACC: begin
                accv  <= pk_res;
                state <= S_POW_SQUARE;
              end
              R_BASE: begin
                basev <= pk_res;
                ev    <= ev >> 1;
                state <= S_POW_CHECK;
              end
              default: begin
                result_value <= pk_res;
                result_valid <= 1'b1;
                busy         <= 1'b0;
                state        <= S_IDLE;
              end
            endcase
          end else begin
            jv    <= pk_res;
            j     <= j - 1'b1;
            state <= S_JOIN_GO;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: rtl/core/gfpm_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "gf_pm_field_alu_top_defines.svh"
module gfpm_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic result_valid
);
  `GFPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted beat did not raise busy")
  `GFPM_ASSERT_NOW(a_strobe_idle, result_valid, !busy, "result strobe while still busy")
  `GFPM_ASSERT_NEXT(a_strobe_single, result_valid, !result_valid, "result strobe repeated")
  `GFPM_ASSERT_NOW(a_busy_end, $fell(busy), result_valid, "busy dropped without a result")
endmodule

bind gf_pm_field_alu_top gfpm_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .result_valid(result_valid)
);
`default_nettype wire
